FILE: hdl/sof_frame_parser_crc16_macros.svh
// Assertion macros for the SOF frame parser.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SOF_FRAME_PARSER_CRC16_MACROS_SVH
`define SOF_FRAME_PARSER_CRC16_MACROS_SVH

// property must hold at every clock outside reset
`define SFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true
`define SFP_NEVER(lbl, cond, msg) \
	`SFP_ASSERT(lbl, !(cond), msg)

`endif

FILE: hdl/sfp_pkg.sv
// Shared types and constants for the SOF frame parser.
// No dependencies.
`default_nettype none

package sfp_pkg;

	localparam int PAYLOAD_DEPTH = 32;
	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int LEN_W = 6;
	localparam int IDX_W = 5;
	localparam int TDATA_W = 48;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam logic [15:0] CRC_MSB = 16'h8000;

	typedef enum logic [0:0] {
		REG_SOF_BYTE = 1'b0,
		REG_MAX_LEN  = 1'b1
	} sfp_reg_t;

	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CRC     = 2'd3
	} sfp_phase_t;

	// emit request from receiver to output sequencer
	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] len;
		logic [7:0]       src_addr;
		logic [7:0]       dest_addr;
		logic [7:0]       msg_type;
	} sfp_emit_req_t;

	// output tdata layout, first field in the highest bits
	typedef struct packed {
		logic [4:0]       pad;
		logic [7:0]       payload_byte;
		logic [IDX_W-1:0] byte_index;
		logic [LEN_W-1:0] payload_len;
		logic [7:0]       msg_type;
		logic [7:0]       dest_addr;
		logic [7:0]       src_addr;
	} sfp_tdata_t;

endpackage

`default_nettype wire

FILE: hdl/sfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sfp_rx.sv
// Receive side: SOF hunt, header, payload write to RAM, CRC-16 check.
// Depends on sfp_pkg.
`default_nettype none

module sfp_rx
	import sfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              acc,
	input  wire logic [7:0]        rx_byte,
	output logic                   ram_we,
	output logic      [ADDR_W-1:0] ram_waddr,
	output sfp_emit_req_t          req
);

	localparam logic [7:0] DEPTH_B = 8'(PAYLOAD_DEPTH);

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	sfp_phase_t       phase_q, phase_d;
	logic [1:0]       hdr_cnt_q, hdr_cnt_d;
	logic [LEN_W-1:0] pay_cnt_q, pay_cnt_d;
	logic [15:0]      crc_q, crc_d;
	logic             lo_seen_q, lo_seen_d;
	logic [7:0]       lo_byte_q, lo_byte_d;
	logic [7:0]       hdr_q [4];
	logic             hdr_wr;
	logic [7:0]       sof_q;
	logic [LEN_W-1:0] max_len_q;
	logic [15:0]      crc_nxt;
	logic [LEN_W-1:0] len;

	assign crc_nxt = crc_byte(crc_q, rx_byte);
	assign len = hdr_q[3][LEN_W-1:0];
	assign ram_waddr = pay_cnt_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_q <= 8'd126;
			max_len_q <= LEN_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOF_BYTE: sof_q <= cfg_data;
				REG_MAX_LEN:  max_len_q <= cfg_data[LEN_W-1:0];
				default:      sof_q <= sof_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			hdr_cnt_q <= 2'd0;
			pay_cnt_q <= '0;
			crc_q <= CRC_INIT;
			lo_seen_q <= 1'b0;
			lo_byte_q <= 8'h00;
		end else begin
			phase_q <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			pay_cnt_q <= pay_cnt_d;
			crc_q <= crc_d;
			lo_seen_q <= lo_seen_d;
			lo_byte_q <= lo_byte_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				hdr_q[i] <= 8'h00;
			end
		end else if (hdr_wr) begin
			hdr_q[hdr_cnt_q] <= rx_byte;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		pay_cnt_d = pay_cnt_q;
		crc_d = crc_q;
		lo_seen_d = lo_seen_q;
		lo_byte_d = lo_byte_q;
		hdr_wr = 1'b0;
		ram_we = 1'b0;
		req.start = 1'b0;
		req.len = len;
		req.src_addr = hdr_q[0];
		req.dest_addr = hdr_q[1];
		req.msg_type = hdr_q[2];
		if (acc) begin
			case (phase_q)
				PH_WAIT: begin
					hdr_cnt_d = 2'd0;
					pay_cnt_d = '0;
					lo_seen_d = 1'b0;
					crc_d = CRC_INIT;
					if (rx_byte == sof_q) begin
						phase_d = PH_HEADER;
					end
				end
				PH_HEADER: begin
					if (hdr_cnt_q != 2'd3) begin
						hdr_wr = 1'b1;
						crc_d = crc_nxt;
						hdr_cnt_d = hdr_cnt_q + 2'd1;
					end else if (rx_byte > {2'b00, max_len_q} || rx_byte > DEPTH_B) begin
						phase_d = PH_WAIT;
					end else begin
						hdr_wr = 1'b1;
						crc_d = crc_nxt;
						hdr_cnt_d = 2'd0;
						phase_d = (rx_byte == 8'h00) ? PH_CRC : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					ram_we = 1'b1;
					crc_d = crc_nxt;
					pay_cnt_d = pay_cnt_q + LEN_W'(1);
					if (pay_cnt_d >= len) begin
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					if (!lo_seen_q) begin
						lo_byte_d = rx_byte;
						lo_seen_d = 1'b1;
					end else begin
						phase_d = PH_WAIT;
						lo_seen_d = 1'b0;
						req.start = ({rx_byte, lo_byte_q} == crc_q);
					end
				end
				default: phase_d = PH_WAIT;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sfp_emit.sv
// Output sequencer: reads stored payload from RAM and drives the result stream.
// Depends on sfp_pkg.
`default_nettype none

module sfp_emit
	import sfp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sfp_emit_req_t      req,
	output logic                    busy,
	output logic                    ram_re,
	output logic       [ADDR_W-1:0] ram_raddr,
	input  wire logic  [7:0]        ram_rdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata,
	output logic                    m_tuser,
	output logic                    m_tlast
);

	logic             act_q;
	logic [LEN_W-1:0] rd_idx_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       src_q, dest_q, type_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             pv_s1, last_s1;
	logic             out_v_q, pv_q, last_q;
	sfp_tdata_t       out_q;
	logic             adv_s1, issue, last_rd;

	assign adv_s1 = v_s1 && (!out_v_q || m_tready);
	assign issue = act_q && (!v_s1 || adv_s1);
	assign last_rd = (len_q == '0) || (rd_idx_q + LEN_W'(1) == len_q);
	assign busy = act_q | v_s1;
	assign ram_re = issue;
	assign ram_raddr = rd_idx_q[ADDR_W-1:0];

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;
	assign m_tuser = pv_q;
	assign m_tlast = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (req.start) begin
				act_q <= 1'b1;
			end else if (issue && last_rd) begin
				act_q <= 1'b0;
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rd_idx_q <= '0;
			len_q <= req.len;
			src_q <= req.src_addr;
			dest_q <= req.dest_addr;
			type_q <= req.msg_type;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + LEN_W'(1);
		end
		if (issue) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
			pv_s1 <= (len_q != '0);
			last_s1 <= last_rd;
		end
		if (adv_s1) begin
			out_q.pad <= '0;
			out_q.payload_byte <= pv_s1 ? ram_rdata : 8'h00;
			out_q.byte_index <= idx_s1;
			out_q.payload_len <= len_q;
			out_q.msg_type <= type_q;
			out_q.dest_addr <= dest_q;
			out_q.src_addr <= src_q;
			pv_q <= pv_s1;
			last_q <= last_s1;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sof_frame_parser_crc16.sv
// SOF frame parser with CRC-16 (poly 0x1021, init 0) check, top level.
// Receive: one byte per cycle while s_tready is high. A good frame blocks input
// while its payload RAM is streamed out, one result per cycle when the output does not stall.
// The first result passes the start flag, the RAM read register and the output register in turn.
// arst_n clears control state; payload RAM is not cleared. Config resets to 126 / 32.
// Depends on sfp_pkg, sfp_ram, sfp_rx, sfp_emit and the assertion macro header.
`default_nettype none
`include "sof_frame_parser_crc16_macros.svh"

module sof_frame_parser_crc16
	import sfp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] rx_byte
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata,   // src_addr, dest_addr, msg_type, payload_len,
	                                           // byte_index, payload_byte, zero pad
	output logic                    m_tuser,   // [0] payload_valid
	output logic                    m_tlast,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data
);

	sfp_emit_req_t     req;
	logic              emit_busy;
	logic              acc;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_rdata;

	assign cfg_ready = 1'b1;
	assign s_tready = !emit_busy;
	assign acc = s_tvalid && s_tready;

	sfp_rx u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.rx_byte   (s_tdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.req       (req)
	);

	sfp_ram #(
		.WIDTH (8),
		.DEPTH (PAYLOAD_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sfp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.busy      (emit_busy),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	`SFP_NEVER(a_no_wr_during_rd, ram_we && ram_re, "payload write while reading out")
	`SFP_NEVER(a_start_when_busy, req.start && emit_busy, "emit request while busy")
	`SFP_ASSERT(a_empty_frame, m_tvalid && !m_tuser |-> m_tlast && m_tdata[34:24] == '0, "bad empty")
	`SFP_ASSERT(a_start_blocks, req.start |=> !s_tready, "input not blocked after emit request")

endmodule

`default_nettype wire

FILE: dv/sof_frame_parser_crc16_checker.sv
`timescale 1ns / 1ps
// CRC-16 byte step shared by stimulus and checking, and the result checker that
// tracks the frame parser from its channels. Depends on sfp_pkg.

package sfp_check_pkg;
	import sfp_pkg::*;

	// poly 0x1021, MSB first
	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = ((c & CRC_MSB) != 16'h0000) ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction
endpackage

module sof_frame_parser_crc16_checker
	import sfp_pkg::*;
	import sfp_check_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,
	input  logic               m_tuser,
	input  logic               m_tlast,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [7:0]       src;
		logic [7:0]       dest;
		logic [7:0]       mtype;
		logic [LEN_W-1:0] len;
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
		logic             tail;
	} beat_t;

	beat_t            beat_q[$];
	logic [7:0]       sof_val;
	logic [LEN_W-1:0] max_len;
	sfp_phase_t       ph;
	logic [1:0]       hdr_cnt;
	logic [7:0]       hdr [4];
	logic [LEN_W-1:0] pay_cnt;
	logic [7:0]       pay_mem [PAYLOAD_DEPTH];
	logic [15:0]      crc;
	logic             lo_seen;
	logic [7:0]       lo_byte;
	int               beat_no = 0;

	initial errors = 0;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		errors++;
		$display("%0t result %0d: %s got %0h expected %0h", $realtime, beat_no, what,
			got, want);
	endtask

	// one received byte through the parser; a good frame queues its results
	task parse_byte(input logic [7:0] b);
		beat_t bt;
		int    n;
		case (ph)
			PH_WAIT: begin
				hdr_cnt = 0;
				pay_cnt = 0;
				lo_seen = 1'b0;
				crc = CRC_INIT;
				if (b == sof_val)
					ph = PH_HEADER;
			end
			PH_HEADER: begin
				if (hdr_cnt < 3) begin
					hdr[hdr_cnt] = b;
					crc = crc16_step(crc, b);
					hdr_cnt++;
				end else if (b > max_len || b > PAYLOAD_DEPTH) begin
					ph = PH_WAIT;
				end else begin
					hdr[3] = b;
					crc = crc16_step(crc, b);
					hdr_cnt = 0;
					ph = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (pay_cnt < hdr[3] && pay_cnt < PAYLOAD_DEPTH) begin
					pay_mem[pay_cnt] = b;
					crc = crc16_step(crc, b);
					pay_cnt++;
				end
				if (pay_cnt >= hdr[3])
					ph = PH_CRC;
			end
			default: begin
				if (!lo_seen) begin
					lo_byte = b;
					lo_seen = 1'b1;
				end else begin
					ph = PH_WAIT;
					lo_seen = 1'b0;
					if ({b, lo_byte} == crc) begin
						bt.src = hdr[0];
						bt.dest = hdr[1];
						bt.mtype = hdr[2];
						if (hdr[3] == 8'd0) begin
							bt.len = '0;
							bt.valid = 1'b0;
							bt.idx = '0;
							bt.data = 8'd0;
							bt.tail = 1'b1;
							beat_q.push_back(bt);
						end else begin
							for (n = 0; n < hdr[3]; n++) begin
								bt.len = hdr[3][LEN_W-1:0];
								bt.valid = 1'b1;
								bt.idx = n[IDX_W-1:0];
								bt.data = pay_mem[n];
								bt.tail = (n + 1 == hdr[3]);
								beat_q.push_back(bt);
							end
						end
					end
				end
			end
		endcase
	endtask

	task check_beat();
		sfp_tdata_t got;
		beat_t      want;
		beat_no++;
		got = m_tdata;
		if (beat_q.size() == 0) begin
			report_mismatch("result with none expected", got.src_addr, 16'h0);
		end else begin
			want = beat_q.pop_front();
			if (got.src_addr !== want.src)
				report_mismatch("src_addr", got.src_addr, want.src);
			if (got.dest_addr !== want.dest)
				report_mismatch("dest_addr", got.dest_addr, want.dest);
			if (got.msg_type !== want.mtype)
				report_mismatch("msg_type", got.msg_type, want.mtype);
			if (got.payload_len !== want.len)
				report_mismatch("payload_len", got.payload_len, want.len);
			if (got.byte_index !== want.idx)
				report_mismatch("byte_index", got.byte_index, want.idx);
			if (got.payload_byte !== want.data)
				report_mismatch("payload_byte", got.payload_byte, want.data);
			if (m_tuser !== want.valid)
				report_mismatch("payload_valid", m_tuser, want.valid);
			if (m_tlast !== want.tail)
				report_mismatch("last", m_tlast, want.tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_val = 8'd126;
			max_len = 6'd32;
			ph = PH_WAIT;
			hdr_cnt = 0;
			foreach (hdr[i])
				hdr[i] = 8'd0;
			pay_cnt = 0;
			crc = CRC_INIT;
			lo_seen = 1'b0;
			lo_byte = 8'd0;
			beat_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (sfp_reg_t'(cfg_index))
					REG_SOF_BYTE: sof_val = cfg_data;
					REG_MAX_LEN:  max_len = cfg_data[LEN_W-1:0];
				endcase
			end
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready)
				parse_byte(s_tdata);
			pending <= beat_q.size();
		end
	end

endmodule

FILE: dv/sof_frame_parser_crc16_test.sv
`timescale 1ns / 1ps
// Top of the frame parser test: clock, reset, byte and register stimulus,
// output back-pressure and verdict. Depends on sfp_pkg and the checker file.

module sof_frame_parser_crc16_test;
	import sfp_pkg::*;
	import sfp_check_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 56;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;
	logic               cfg_valid;
	logic               cfg_ready;
	sfp_reg_t           cfg_index;
	logic [7:0]         cfg_data;
	int                 errors;
	int                 pending;
	int                 sent = 0;
	logic               calm = 1'b0;
	logic               hold_req = 1'b0;
	logic [7:0]         cur_sof = 8'd126;
	logic [LEN_W-1:0]   cur_max = 6'd32;
	logic [7:0]         body[$];
	wire                moving = (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
	                             (cfg_valid && cfg_ready);

	sof_frame_parser_crc16 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sof_frame_parser_crc16_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// called at a falling edge, returns at a falling edge
	task send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 28) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	task write_reg(input sfp_reg_t idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// drain predicted results, then allow for a frame still in flight
	task settle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// header, body (when the length is accepted) and CRC low byte first;
	// cut != 0 sends only the first cut bytes
	task send_frame(input logic [7:0] src, input logic [7:0] dest, input logic [7:0] mtype,
			input logic [7:0] len, input logic bad_crc, input int cut);
		logic [7:0]  frame[$];
		logic [15:0] crc;
		int          n;
		frame = {cur_sof, src, dest, mtype, len};
		if (len <= cur_max) begin
			crc = CRC_INIT;
			for (n = 1; n < 5; n++)
				crc = crc16_step(crc, frame[n]);
			foreach (body[i]) begin
				crc = crc16_step(crc, body[i]);
				frame.push_back(body[i]);
			end
			if (bad_crc)
				crc ^= 16'h0001 << $urandom_range(0, 15);
			frame.push_back(crc[7:0]);
			frame.push_back(crc[15:8]);
		end
		n = (cut != 0 && cut < frame.size()) ? cut : frame.size();
		for (int i = 0; i < n; i++)
			send_byte(frame[i]);
	endtask

	task fill_body(input int len);
		body.delete();
		repeat (len) body.push_back($urandom_range(0, 255));
	endtask

	task random_frame();
		logic [7:0] len;
		int         r;
		int         cut;
		if ($urandom_range(0, 99) < 20)
			repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 10)
			len = cur_max;
		else if (r < 15 && cur_max < 32)
			len = $urandom_range(int'(cur_max) + 1, 32);
		else if (r < 20)
			len = $urandom_range(33, 255);
		else
			len = $urandom_range(0, (cur_max < 8) ? cur_max : 8);
		fill_body((len <= cur_max) ? len : 0);
		cut = ($urandom_range(0, 99) < 5) ? $urandom_range(1, 6 + len) : 0;
		send_frame($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			len, $urandom_range(0, 99) < 10, cut);
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 28);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || moving)
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int mark;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = REG_SOF_BYTE;
		cfg_data = 8'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty payload, good CRC
		body.delete();
		send_frame(8'h00, 8'hFF, 8'hA5, 8'd0, 1'b0, 0);
		// length just above the store depth
		send_frame(8'h11, 8'h22, 8'h33, 8'd33, 1'b0, 0);
		// start byte and all-ones inside the payload
		body = {cur_sof, 8'hFF};
		send_frame(8'hFF, 8'h00, 8'h00, 8'd2, 1'b0, 0);
		// CRC mismatch
		body.delete();
		send_frame(8'h5A, 8'hC3, 8'h81, 8'd0, 1'b1, 0);

		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: begin cur_sof = 8'h00; cur_max = 6'd0; end
					2: begin cur_sof = 8'hFF; cur_max = 6'd32; end
					3: begin cur_sof = $urandom_range(0, 255); cur_max = $urandom_range(1, 31); end
					default: begin cur_sof = 8'd126; cur_max = 6'd5; end
				endcase
				write_reg(REG_SOF_BYTE, cur_sof);
				write_reg(REG_MAX_LEN, {2'b00, cur_max});
				cfg_valid <= 1'b0;
			end
			calm = (p == 2);
			if (p == 3)
				hold_req = 1'b1;
			mark = sent;
			fill_body(cur_max);
			send_frame($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
				cur_max, 1'b0, 0);
			while (sent - mark < ITEMS_PER_PHASE)
				random_frame();
		end
		settle();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sfp_pkg.sv
hdl/sfp_ram.sv
hdl/sfp_rx.sv
hdl/sfp_emit.sv
hdl/sof_frame_parser_crc16.sv
dv/sof_frame_parser_crc16_checker.sv
dv/sof_frame_parser_crc16_test.sv
